[sv/dcdts_pkg.sv]
// Package with the character codes and widths shared by the date tag scanner.
`timescale 1ns / 1ps

package dcdts_pkg;

  // Width of the reported offsets
  localparam int unsigned OffsetWidth = 32;
  // Default width of the running byte counter
  localparam int unsigned PositionBitsDefault = 32;

  // Characters the scanner reacts to
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

endpackage

[sv/dcdts_if.sv]
// Stream interfaces for the byte input and the tag result output.
`timescale 1ns / 1ps

interface dcdts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface dcdts_result_if
  import dcdts_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OffsetWidth-1:0] date_start;
  logic [OffsetWidth-1:0] date_end;

  modport source (output valid, output found, output date_start, output date_end,
                  input ready);
  modport sink   (input valid, input found, input date_start, input date_end,
                  output ready);
endinterface

[sv/doc_comment_date_tag_scanner.sv]
// Top level of the documentation comment date tag scanner.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------
//   in_i    | in  | valid / ready | byte_value[7:0], last_byte
//   out_o   | out | valid / ready | found, date_start[31:0], date_end[31:0]
//
// One byte per cycle while results are taken; an accepted byte lands in the
// input register, and any result due is then shown from the result register.
// Each byte takes at most two state evaluations, both in the same cycle.
// Reset clears the scan state, the byte counter and both valid flags.
// A stalled result holds the result register; the input register still takes
// one more byte, then ready drops until the result is taken.
`timescale 1ns / 1ps

module doc_comment_date_tag_scanner
  import dcdts_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcdts_byte_if.sink     in_i,
  dcdts_result_if.source out_o
);

  typedef enum logic [3:0] {
    StIdle      = 4'd0,
    StSlash     = 4'd1,
    StOpen      = 4'd2,
    StDocBody   = 4'd3,
    StDocStar   = 4'd4,
    StTagAt     = 4'd5,
    StTagD      = 4'd6,
    StTagA      = 4'd7,
    StTagT      = 4'd8,
    StTagBlank  = 4'd9,
    StTagValue  = 4'd10,
    StDone      = 4'd11,
    StPlainBody = 4'd12,
    StPlainStar = 4'd13
  } scan_state_e;

  typedef struct packed {
    scan_state_e next;
    logic        again;
  } step_t;

  // One evaluation of the scan machine on one byte
  function automatic step_t eval_step(scan_state_e st, logic [7:0] ch);
    step_t r;
    r.again = 1'b0;
    r.next  = StIdle;
    case (st)
      StSlash: begin
        if (ch == ChStar) r.next = StOpen;
        else begin r.next = StIdle; r.again = 1'b1; end
      end
      StOpen: begin
        if (ch == ChStar) r.next = StDocBody;
        else begin r.next = StPlainBody; r.again = 1'b1; end
      end
      StDocBody: begin
        if (ch == ChAt) r.next = StTagAt;
        else if (ch == ChStar) r.next = StDocStar;
        else r.next = StDocBody;
      end
      StDocStar: begin
        if (ch == ChSlash) r.next = StIdle;
        else begin r.next = StDocBody; r.again = 1'b1; end
      end
      StTagAt: begin
        if (ch == ChD) r.next = StTagD;
        else begin r.next = StDocBody; r.again = 1'b1; end
      end
      StTagD: begin
        if (ch == ChA) r.next = StTagA;
        else begin r.next = StDocBody; r.again = 1'b1; end
      end
      StTagA: begin
        if (ch == ChT) r.next = StTagT;
        else begin r.next = StDocBody; r.again = 1'b1; end
      end
      StTagT: begin
        if (ch == ChE) r.next = StTagBlank;
        else begin r.next = StDocBody; r.again = 1'b1; end
      end
      StTagBlank: begin
        if (ch == ChNl) r.next = StDone;
        else if (ch != ChSp && ch != ChTab) r.next = StTagValue;
        else r.next = StTagBlank;
      end
      StTagValue: begin
        if (ch == ChNl) r.next = StDone;
        else r.next = StTagValue;
      end
      StDone: r.next = StDone;
      StPlainBody: begin
        if (ch == ChStar) r.next = StPlainStar;
        else r.next = StPlainBody;
      end
      StPlainStar: begin
        if (ch == ChSlash) r.next = StIdle;
        else if (ch == ChStar) r.next = StPlainStar;
        else r.next = StPlainBody;
      end
      default: begin
        if (ch == ChSlash) r.next = StSlash;
        else r.next = StIdle;
      end
    endcase
    return r;
  endfunction

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Scan state
  scan_state_e              state_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] start_q;
  logic                     start_seen_q;
  logic                     finished_q;

  // Result register
  logic                   res_valid_q;
  logic                   res_found_q;
  logic [OffsetWidth-1:0] res_start_q;
  logic [OffsetWidth-1:0] res_end_q;

  logic advance;
  logic process;

  assign advance  = !res_valid_q || out_o.ready;
  assign process  = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Evaluate the held byte, with one re-examination in the fallback state
  step_t       step_a;
  step_t       step_b;
  scan_state_e prev_state;
  scan_state_e next_state;
  logic        start_hit;
  logic        done;
  logic        emit;

  logic [POSITION_BITS+OffsetWidth-1:0] here_ext;
  logic [POSITION_BITS+OffsetWidth-1:0] start_ext;
  logic [OffsetWidth-1:0]               here_off;
  logic [OffsetWidth-1:0]               start_off;

  always_comb begin
    step_a     = eval_step(state_q, in_byte_q);
    prev_state = step_a.again ? step_a.next : state_q;
    step_b     = eval_step(prev_state, in_byte_q);
    next_state = step_a.again ? step_b.next : step_a.next;
    start_hit  = (next_state != prev_state) && (next_state == StTagValue);
    done       = (next_state == StDone);
    emit       = !finished_q && (done || in_last_q);
  end

  // Offsets are reported in their low bits, zero extended when narrower
  assign here_ext  = {{OffsetWidth{1'b0}}, pos_q};
  assign start_ext = {{OffsetWidth{1'b0}}, start_q};
  assign here_off  = here_ext[OffsetWidth-1:0];
  assign start_off = start_ext[OffsetWidth-1:0];

  // Load the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.byte_value;
      in_last_q <= in_i.last_byte;
    end
  end

  // Advance the scan state; ignore bytes after a found tag until the file ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pos_q        <= '0;
      start_q      <= '0;
      start_seen_q <= 1'b0;
      finished_q   <= 1'b0;
    end else if (process) begin
      if (in_last_q) begin
        state_q      <= StIdle;
        pos_q        <= '0;
        start_q      <= '0;
        start_seen_q <= 1'b0;
        finished_q   <= 1'b0;
      end else if (!finished_q) begin
        state_q <= next_state;
        pos_q   <= pos_q + 1'b1;
        if (start_hit) begin
          start_q      <= pos_q;
          start_seen_q <= 1'b1;
        end
        if (done) begin
          finished_q <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= process && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      res_found_q <= done;
      res_start_q <= done ? (start_seen_q ? start_off : here_off) : '0;
      res_end_q   <= done ? here_off : '0;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.found      = res_found_q;
  assign out_o.date_start = res_start_q;
  assign out_o.date_end   = res_end_q;

endmodule

[sv/dcdts_checker.sv]
// Port-level checks for the date tag scanner, bound to the top level.
`timescale 1ns / 1ps

module dcdts_checker
  import dcdts_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_found_i,
  input logic [OffsetWidth-1:0] out_date_start_i,
  input logic [OffsetWidth-1:0] out_date_end_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_found_i)
      && $stable(out_date_start_i) && $stable(out_date_end_i))
    else $error("stalled result changed");

  // A result without the tag carries zero offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_date_start_i == '0 && out_date_end_i == '0)
    else $error("end-of-file result with nonzero offsets");

  // A fresh result follows an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without an accepted item");

  // An empty output side never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

endmodule

bind doc_comment_date_tag_scanner dcdts_checker u_dcdts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_found_i      (out_o.found),
  .out_date_start_i (out_o.date_start),
  .out_date_end_i   (out_o.date_end)
);

[tb/doc_comment_date_tag_scanner_tb.sv]
// Testbench for the documentation comment date tag scanner: byte streams in, checked results out.
`timescale 1ns / 1ps

module doc_comment_date_tag_scanner_tb;
  import dcdts_pkg::*;

  // Scanner states, numbered as the block numbers them
  typedef enum logic [3:0] {
    ScanIdle      = 4'd0,
    ScanSlash     = 4'd1,
    ScanOpen      = 4'd2,
    ScanDoc       = 4'd3,
    ScanDocStar   = 4'd4,
    ScanAt        = 4'd5,
    ScanD         = 4'd6,
    ScanA         = 4'd7,
    ScanT         = 4'd8,
    ScanTag       = 4'd9,
    ScanValue     = 4'd10,
    ScanDone      = 4'd11,
    ScanPlain     = 4'd12,
    ScanPlainStar = 4'd13
  } scan_e;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic                   found;
    logic [OffsetWidth-1:0] date_start;
    logic [OffsetWidth-1:0] date_end;
  } tag_result_t;

  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcdts_byte_if   byte_if ();
  dcdts_result_if res_if ();

  doc_comment_date_tag_scanner u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  text_byte_t  text_q[$];
  tag_result_t tag_result_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned hold_left     = 0;
  bit          hold_arm      = 1'b0;
  bit          hold_ack      = 1'b0;

  // Scanner model state
  scan_e                        scan_st;
  scan_e                        prev_st;
  scan_e                        next_st;
  logic [PositionBitsDefault-1:0] scan_pos;
  logic [PositionBitsDefault-1:0] here;
  logic [PositionBitsDefault-1:0] date_off;
  bit                           date_seen;
  bit                           scan_done;
  bit                           again;

  always #5 clk_i = ~clk_i;

  // One state evaluation; flag a byte that must be looked at again in the fallback state
  function automatic scan_e next_scan(input scan_e st, input logic [7:0] ch, output bit redo);
    scan_e nxt;
    redo = 1'b0;
    case (st)
      ScanSlash: begin
        if (ch == ChStar) nxt = ScanOpen;
        else begin
          nxt  = ScanIdle;
          redo = 1'b1;
        end
      end
      ScanOpen: begin
        if (ch == ChStar) nxt = ScanDoc;
        else begin
          nxt  = ScanPlain;
          redo = 1'b1;
        end
      end
      ScanDoc: begin
        if (ch == ChAt) nxt = ScanAt;
        else if (ch == ChStar) nxt = ScanDocStar;
        else nxt = ScanDoc;
      end
      ScanDocStar: begin
        if (ch == ChSlash) nxt = ScanIdle;
        else begin
          nxt  = ScanDoc;
          redo = 1'b1;
        end
      end
      ScanAt, ScanD, ScanA, ScanT: begin
        if ((st == ScanAt && ch == ChD) || (st == ScanD && ch == ChA) ||
            (st == ScanA && ch == ChT)) begin
          nxt = scan_e'(st + 4'd1);
        end else if (st == ScanT && ch == ChE) begin
          nxt = ScanTag;
        end else begin
          nxt  = ScanDoc;
          redo = 1'b1;
        end
      end
      ScanTag: begin
        if (ch == ChNl) nxt = ScanDone;
        else if (ch != ChSp && ch != ChTab) nxt = ScanValue;
        else nxt = ScanTag;
      end
      ScanValue: nxt = (ch == ChNl) ? ScanDone : ScanValue;
      ScanDone:  nxt = ScanDone;
      ScanPlain: nxt = (ch == ChStar) ? ScanPlainStar : ScanPlain;
      ScanPlainStar: begin
        if (ch == ChSlash) nxt = ScanIdle;
        else if (ch == ChStar) nxt = ScanPlainStar;
        else nxt = ScanPlain;
      end
      default: nxt = (ch == ChSlash) ? ScanSlash : ScanIdle;
    endcase
    return nxt;
  endfunction

  task automatic put_byte(input logic [7:0] value, input logic last);
    text_q.push_back('{value: value, last: last});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || byte_if.valid || tag_result_q.size() != 0) @(posedge clk_i);
  endtask

  // Fill with random files until the item count is reached, then let everything drain
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_items);
    string       frags[19];
    int unsigned queued;
    int unsigned n_frags;
    frags = '{"/**", "/*", "*/", "@date", "@date ", "@date\t", " ", "\t", "\n", "*", "/",
              "@", "@dat", "@@date", "**/", "/***/", "x", "rev-17b",
              "/**\n * @date v4.2\n */\n"};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queued = 0;
    while (queued < n_items) begin
      queued -= text_q.size();
      if ($urandom_range(9) < 6) put_text("/**");
      n_frags = $urandom_range(1, 10);
      for (int f = 0; f < n_frags; f++) begin
        if ($urandom_range(99) < 15) put_byte(8'($urandom_range(255)), 1'b0);
        else put_text(frags[$urandom_range(18)]);
      end
      text_q[$].last = 1'b1;
      queued += text_q.size();
    end
    wait_drained();
  endtask

  // Drive input items; update the model on each accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    text_byte_t nxt_item;
    if (!rst_ni) begin
      byte_if.valid      <= 1'b0;
      byte_if.byte_value <= 8'h00;
      byte_if.last_byte  <= 1'b0;
      scan_st   = ScanIdle;
      scan_pos  = '0;
      date_off  = '0;
      date_seen = 1'b0;
      scan_done = 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        if (!scan_done) begin
          here    = scan_pos;
          prev_st = scan_st;
          next_st = next_scan(prev_st, byte_if.byte_value, again);
          if (again) begin
            prev_st = next_st;
            next_st = next_scan(prev_st, byte_if.byte_value, again);
          end
          if (next_st != prev_st && next_st == ScanValue) begin
            date_off  = here;
            date_seen = 1'b1;
          end
          scan_st = next_st;
          if (next_st == ScanDone) begin
            tag_result_q.push_back('{found: 1'b1,
                                     date_start: date_seen ? date_off : here,
                                     date_end: here});
            scan_done = 1'b1;
          end else if (byte_if.last_byte) begin
            tag_result_q.push_back('{found: 1'b0, date_start: '0, date_end: '0});
          end
          scan_pos = scan_pos + 1'b1;
        end
        // End of file: start over for the next one
        if (byte_if.last_byte) begin
          scan_st   = ScanIdle;
          scan_pos  = '0;
          date_off  = '0;
          date_seen = 1'b0;
          scan_done = 1'b0;
        end
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_item = text_q.pop_front();
          byte_if.valid      <= 1'b1;
          byte_if.byte_value <= nxt_item.value;
          byte_if.last_byte  <= nxt_item.last;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long receiver hold-off when armed
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm != hold_ack) begin
      hold_left <= HoldCycles;
      hold_ack  <= hold_arm;
    end
  end

  // Take results and check them against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    tag_result_t exp_res;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (tag_result_q.size() == 0) begin
          $error("unexpected result: found=%0b date_start=%0d date_end=%0d",
                 res_if.found, res_if.date_start, res_if.date_end);
          mismatch_cnt++;
        end else begin
          exp_res = tag_result_q.pop_front();
          if (res_if.found !== exp_res.found) begin
            $error("found: expected %0b, got %0b", exp_res.found, res_if.found);
            mismatch_cnt++;
          end
          if (res_if.date_start !== exp_res.date_start) begin
            $error("date_start: expected %0d, got %0d", exp_res.date_start, res_if.date_start);
            mismatch_cnt++;
          end
          if (res_if.date_end !== exp_res.date_end) begin
            $error("date_end: expected %0d, got %0d", exp_res.date_end, res_if.date_end);
            mismatch_cnt++;
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tag after a retried '@', blanks then a value, newline on the last byte
    send_idle_pct = 18;
    recv_idle_pct = 50;
    put_text("/**@@date\t 1\n");
    text_q[$].last = 1'b1;
    // Directed: extreme byte values, file without a comment
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b1);
    // Directed: tag inside a plain comment does not count
    put_text("/*@date\n*/Z");
    text_q[$].last = 1'b1;
    wait_drained();

    // Random files under both idling mixes; each phase pauses until all results are in
    run_phase(18, 50, 330);
    run_phase(50, 18, 330);

    // Hold the receiver off while the sender keeps offering
    hold_arm = ~hold_arm;
    run_phase(0, 0, 80);

    run_phase(0, 0, 300);

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[doc_comment_date_tag_scanner.f]
sv/dcdts_pkg.sv
sv/dcdts_if.sv
sv/doc_comment_date_tag_scanner.sv
sv/dcdts_checker.sv
tb/doc_comment_date_tag_scanner_tb.sv
